@@ design/lzte_pkg.sv @@
package lzte_pkg;

	// History window and lane configuration.
	localparam int WINDOW_DEPTH = 32768;
	localparam int OUT_LANES    = 4;
	localparam int LANES        = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);
	localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
	localparam int CALC_W       = (HIST_AW + 1 > 17) ? HIST_AW + 1 : 17;

	// Sticky error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_BAD_OFFSET = 2'd1;
	localparam logic [1:0] ERR_ZERO_LEN   = 2'd2;

	// Status codes reported with each result.
	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_SIZE_MISMATCH = 3'd3;
	localparam logic [2:0] ST_TRUNCATED     = 3'd4;

	typedef logic [HIST_AW-1:0] hist_addr_t;

	// Advance a history pointer, wrapping at the end of the window.
	function automatic hist_addr_t next_ptr(input hist_addr_t ptr);
		if (ptr == HIST_AW'(WINDOW_DEPTH - 1)) begin
			return '0;
		end
		return ptr + hist_addr_t'(1);
	endfunction

endpackage

@@ design/lzte_if.sv @@
// Configuration write channel.
interface lzte_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] expected_size;

	modport source (output valid, output expected_size, input ready);
	modport sink (input valid, input expected_size, output ready);
endinterface

// Token request channel.
interface lzte_tok_if;
	logic        valid;
	logic        ready;
	logic        is_literal;
	logic [7:0]  literal_byte;
	logic [15:0] match_offset;
	logic [7:0]  match_length;
	logic        last_token;

	modport source (output valid, output is_literal, output literal_byte, output match_offset,
		output match_length, output last_token, input ready);
	modport sink (input valid, input is_literal, input literal_byte, input match_offset,
		input match_length, input last_token, output ready);
endinterface

// Result request channel.
interface lzte_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_0;
	logic [7:0] byte_1;
	logic [7:0] byte_2;
	logic [7:0] byte_3;
	logic [2:0] byte_count;
	logic       run_end;
	logic [2:0] status;

	modport source (output valid, output byte_0, output byte_1, output byte_2, output byte_3,
		output byte_count, output run_end, output status, input ready);
	modport sink (input valid, input byte_0, input byte_1, input byte_2, input byte_3,
		input byte_count, input run_end, input status, output ready);
endinterface

@@ design/lzte_history.sv @@
// History window: one write port, one registered read port. A read of the
// entry being written in the same cycle returns the old contents.
module lzte_history import lzte_pkg::*; (
	input  logic       clk,
	input  logic       we,
	input  hist_addr_t waddr,
	input  logic [7:0] wdata,
	input  logic       re,
	input  hist_addr_t raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [WINDOW_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued, so a stalled consumer keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/lzss_token_expander_top.sv @@
// LZSS token expander. Each token request gives one or more result requests of
// up to four bytes, the last one flagged run_end. Tokens are handled one at a
// time: a token is latched, checked, expanded byte by byte into groups and
// flushed, and the next token is taken only after its final result request is
// loaded. A match emits up to its length in bytes and a literal at most one.
// The bytes of a match come from the history memory, which delivers one byte
// per cycle through its single read port unless output back-pressure stalls it.
// Output back-pressure stalls the byte loop whenever a full group of bytes
// cannot be handed on. The expected size register may be written only while no
// token is in flight.
module lzss_token_expander_top import lzte_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	lzte_cfg_if.sink   cfg,
	lzte_tok_if.sink   tok,
	lzte_res_if.source res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_RUN,
		S_FLUSH
	} state_t;

	state_t     state_q;
	logic [31:0] expected_q;
	logic [31:0] produced_q;
	hist_addr_t wp_q;
	logic [1:0] err_q;
	logic       overrun_q;
	logic [7:0] last_byte_q;

	// Latched token.
	logic        lit_q;
	logic [7:0]  lbyte_q;
	logic [15:0] off_q;
	logic [7:0]  len_q;
	logic        last_q;

	// Byte loop.
	logic [7:0] left_q;
	hist_addr_t rd_ptr_q;
	logic       s2_valid_q;
	logic [7:0] grp_q [4];
	logic [2:0] grp_cnt_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q [4];
	logic [2:0] out_cnt_q;
	logic       out_end_q;
	logic [2:0] out_status_q;

	logic [32:0]       diff;
	logic              rem_zero;
	logic              rem_big;
	logic              len_gt_rem;
	logic [7:0]        match_n;
	logic              bad_off;
	logic [CALC_W-1:0] wp_ext;
	logic [CALC_W-1:0] off_ext;
	logic [CALC_W-1:0] rd_start;
	logic              out_free;
	logic              grp_full;
	logic              stall;
	logic              s2_acc;
	logic              mid_flush;
	logic              flush_go;
	logic              issue;
	logic [7:0]        ram_rdata;
	logic [7:0]        s2_byte;
	logic [2:0]        live_status;
	logic [2:0]        final_status;

	// Room left before the expected size, and the offset checks.
	always_comb begin
		diff       = {1'b0, expected_q} - {1'b0, produced_q};
		rem_zero   = diff[32] || (diff == '0);
		rem_big    = !rem_zero && (|diff[31:8]);
		len_gt_rem = !rem_big && (rem_zero || (len_q > diff[7:0]));
		match_n    = len_gt_rem ? (rem_zero ? 8'd0 : diff[7:0]) : len_q;
		bad_off    = (off_q == 16'd0) || (32'(off_q) > produced_q)
			|| (32'(off_q) > 32'(WINDOW_DEPTH));
		wp_ext     = CALC_W'(wp_q);
		off_ext    = CALC_W'(off_q);
		rd_start   = (wp_ext >= off_ext) ? wp_ext - off_ext
			: wp_ext + CALC_W'(WINDOW_DEPTH) - off_ext;
	end

	// Flow control of the byte loop.
	always_comb begin
		out_free  = !out_valid_q || res.ready;
		grp_full  = (grp_cnt_q == 3'(LANES));
		stall     = s2_valid_q && grp_full && !out_free;
		s2_acc    = s2_valid_q && !stall;
		mid_flush = s2_valid_q && grp_full && out_free;
		flush_go  = (state_q == S_FLUSH) && out_free;
		issue     = (state_q == S_RUN) && (left_q != 8'd0) && !stall;
	end

	// A distance of one repeats the byte just produced, which may not be in
	// the memory yet; every longer distance reads an entry already written.
	always_comb begin
		if (lit_q) begin
			s2_byte = lbyte_q;
		end else if (off_q == 16'd1) begin
			s2_byte = last_byte_q;
		end else begin
			s2_byte = ram_rdata;
		end
	end

	// Status of the results of the token in progress.
	always_comb begin
		if (err_q != ERR_NONE) begin
			live_status = {1'b0, err_q};
		end else if (overrun_q) begin
			live_status = ST_TRUNCATED;
		end else begin
			live_status = ST_OK;
		end
		if (err_q != ERR_NONE) begin
			final_status = {1'b0, err_q};
		end else if (produced_q != expected_q) begin
			final_status = ST_SIZE_MISMATCH;
		end else begin
			final_status = live_status;
		end
	end

	lzte_history u_history (
		.clk   (clk),
		.we    (s2_acc),
		.waddr (wp_q),
		.wdata (s2_byte),
		.re    (issue),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// Token sequencer, byte loop and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			expected_q  <= '0;
			produced_q  <= '0;
			wp_q        <= '0;
			err_q       <= ERR_NONE;
			overrun_q   <= 1'b0;
			left_q      <= '0;
			s2_valid_q  <= 1'b0;
			grp_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				expected_q <= cfg.expected_size;
			end

			// The output register is loaded by a full group or by the final group.
			if (mid_flush || flush_go) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			// Memory read stage.
			if (issue) begin
				rd_ptr_q   <= next_ptr(rd_ptr_q);
				left_q     <= left_q - 8'd1;
				s2_valid_q <= 1'b1;
			end else if (s2_acc) begin
				s2_valid_q <= 1'b0;
			end

			// Byte commit: history write and packing into the lane group.
			if (s2_acc) begin
				wp_q        <= next_ptr(wp_q);
				produced_q  <= produced_q + 32'd1;
				last_byte_q <= s2_byte;
				if (mid_flush) begin
					out_byte_q    <= grp_q;
					out_cnt_q     <= grp_cnt_q;
					out_end_q     <= 1'b0;
					out_status_q  <= live_status;
					grp_q         <= '{s2_byte, 8'd0, 8'd0, 8'd0};
					grp_cnt_q     <= 3'd1;
				end else begin
					grp_q[grp_cnt_q[1:0]] <= s2_byte;
					grp_cnt_q             <= grp_cnt_q + 3'd1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (tok.valid) begin
						lit_q   <= tok.is_literal;
						lbyte_q <= tok.literal_byte;
						off_q   <= tok.match_offset;
						len_q   <= tok.match_length;
						last_q  <= tok.last_token;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					grp_q     <= '{default: 8'd0};
					grp_cnt_q <= '0;
					rd_ptr_q  <= HIST_AW'(rd_start);
					if (err_q != ERR_NONE) begin
						left_q <= '0;
					end else if (lit_q) begin
						left_q <= rem_zero ? 8'd0 : 8'd1;
						if (rem_zero) begin
							overrun_q <= 1'b1;
						end
					end else if (bad_off) begin
						left_q <= '0;
						err_q  <= ERR_BAD_OFFSET;
					end else if (len_q == 8'd0) begin
						left_q <= '0;
						err_q  <= ERR_ZERO_LEN;
					end else begin
						left_q <= match_n;
						if (len_gt_rem) begin
							overrun_q <= 1'b1;
						end
					end
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (left_q == 8'd0 && !s2_valid_q) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_byte_q   <= grp_q;
						out_cnt_q    <= grp_cnt_q;
						out_end_q    <= 1'b1;
						out_status_q <= last_q ? final_status : live_status;
						if (last_q) begin
							produced_q <= '0;
							wp_q       <= '0;
							err_q      <= ERR_NONE;
							overrun_q  <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg.ready      = 1'b1;
	assign tok.ready      = (state_q == S_IDLE);
	assign res.valid      = out_valid_q;
	assign res.byte_0     = out_byte_q[0];
	assign res.byte_1     = out_byte_q[1];
	assign res.byte_2     = out_byte_q[2];
	assign res.byte_3     = out_byte_q[3];
	assign res.byte_count = out_cnt_q;
	assign res.run_end    = out_end_q;
	assign res.status     = out_status_q;

endmodule
